### rtl/spsp_pkg.sv
// Shared types and constants for the SPI slave packet sender.
// No dependencies; used by every module of the block.
`default_nettype none

package spsp_pkg;

    // Packet layout: four sonar bytes, one lap byte, one checksum byte
    localparam int PACKET_BYTES = 6;
    localparam int SONAR_BYTES  = 4;
    localparam int LAP_IDX      = 4;
    localparam int SUM_IDX      = 5;
    localparam int CNT_W        = 3;

    // Lap value that marks the one-entry buffer as empty
    localparam logic [7:0] EMPTY_LAP = 8'hFF;

    // Request kinds carried on the input tuser bit
    localparam logic REQ_NEW_DATA  = 1'b0;
    localparam logic REQ_BYTE_DONE = 1'b1;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;
    localparam int RESULT_W   = 11;

    typedef logic [7:0] byte_t;

    // One input transaction, unpacked
    typedef struct packed {
        logic                   req_type;
        byte_t [SONAR_BYTES-1:0] sonar;
        byte_t                  lap;
        logic                   select_idle;
    } req_t;

    // One result transaction; load_valid in the lowest bit
    typedef struct packed {
        logic  buffer_full;
        logic  data_ready;
        byte_t load_byte;
        logic  load_valid;
    } result_t;

endpackage

`default_nettype wire

### rtl/spsp_core.sv
// Packet state and single-step update for the SPI slave packet sender.
// Depends on spsp_pkg; the result is registered downstream in spsp_out_buf.
`default_nettype none

module spsp_core
(
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic accept,
    input  wire spsp_pkg::req_t       req,
    output spsp_pkg::result_t         result
);

    spsp_pkg::byte_t [spsp_pkg::PACKET_BYTES-1:0] packet_reg;
    spsp_pkg::byte_t [spsp_pkg::PACKET_BYTES-1:0] packet_next;
    spsp_pkg::byte_t [spsp_pkg::SONAR_BYTES-1:0]  pend_sonar_reg;
    spsp_pkg::byte_t [spsp_pkg::SONAR_BYTES-1:0]  pend_sonar_next;
    spsp_pkg::byte_t                              pend_lap_reg;
    spsp_pkg::byte_t                              pend_lap_next;
    logic [spsp_pkg::CNT_W-1:0]                   count_reg;
    logic [spsp_pkg::CNT_W-1:0]                   count_next;
    logic                                         ready_reg;
    logic                                         ready_next;
    logic                                         wrap;
    spsp_pkg::byte_t                              byte_out;

    // Work out the next state and the result of the current transaction
    always_comb
    begin
        packet_next     = packet_reg;
        pend_sonar_next = pend_sonar_reg;
        pend_lap_next   = pend_lap_reg;
        count_next      = count_reg;
        ready_next      = ready_reg;
        byte_out        = '0;
        wrap            = (count_reg >= spsp_pkg::CNT_W'(spsp_pkg::PACKET_BYTES));

        if (req.req_type == spsp_pkg::REQ_NEW_DATA)
        begin
            if (req.select_idle)
            begin
                // Form the packet at once and hand out byte 0
                packet_next[spsp_pkg::SONAR_BYTES-1:0] = req.sonar;
                packet_next[spsp_pkg::LAP_IDX]         = req.lap;
                packet_next[spsp_pkg::SUM_IDX]         = req.sonar[0] ^ req.sonar[1]
                                                       ^ req.sonar[2] ^ req.sonar[3]
                                                       ^ req.lap;
                byte_out   = req.sonar[0];
                count_next = spsp_pkg::CNT_W'(1);
                ready_next = 1'b1;
            end
            else
            begin
                // Transfer running: overwrite the buffer
                pend_sonar_next = req.sonar;
                pend_lap_next   = req.lap;
            end
        end
        else if (wrap)
        begin
            // End of packet: load the buffered one if present, else repeat
            ready_next = 1'b0;
            count_next = spsp_pkg::CNT_W'(1);
            if (pend_lap_reg != spsp_pkg::EMPTY_LAP)
            begin
                packet_next[spsp_pkg::SONAR_BYTES-1:0] = pend_sonar_reg;
                packet_next[spsp_pkg::LAP_IDX]         = pend_lap_reg;
                packet_next[spsp_pkg::SUM_IDX]         = pend_sonar_reg[0] ^ pend_sonar_reg[1]
                                                       ^ pend_sonar_reg[2] ^ pend_sonar_reg[3]
                                                       ^ pend_lap_reg;
                pend_lap_next = spsp_pkg::EMPTY_LAP;
                ready_next    = 1'b1;
                byte_out      = pend_sonar_reg[0];
            end
            else
            begin
                byte_out = packet_reg[0];
            end
        end
        else
        begin
            // Advance to the next byte of the packet
            byte_out   = packet_reg[count_reg];
            count_next = count_reg + spsp_pkg::CNT_W'(1);
        end
    end

    // Assemble the result for the output buffer
    always_comb
    begin
        result.load_valid  = (req.req_type == spsp_pkg::REQ_BYTE_DONE) || req.select_idle;
        result.load_byte   = byte_out;
        result.data_ready  = ready_next;
        result.buffer_full = (pend_lap_next != spsp_pkg::EMPTY_LAP);
    end

    // Control state, cleared on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_reg   <= '0;
            pend_lap_reg <= spsp_pkg::EMPTY_LAP;
            count_reg    <= '0;
            ready_reg    <= 1'b0;
        end
        else if (accept)
        begin
            packet_reg   <= packet_next;
            pend_lap_reg <= pend_lap_next;
            count_reg    <= count_next;
            ready_reg    <= ready_next;
        end
    end

    // Buffered sonar bytes: meaningful only once written
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_sonar_reg <= pend_sonar_next;
        end
    end

`ifndef ASSERT_OFF
    // The byte counter never runs past the wrap value
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= spsp_pkg::CNT_W'(spsp_pkg::PACKET_BYTES))
        else $error("byte counter out of range");

    // State changes only on an accepted transaction
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg) && $stable(ready_reg) && $stable(pend_lap_reg))
        else $error("state changed without a transaction");
`endif

endmodule

`default_nettype wire

### rtl/spsp_out_buf.sv
// Two-entry output buffer (result register plus skid register).
// Depends on spsp_pkg for the result type.
`default_nettype none

module spsp_out_buf
(
    input  wire                   logic clk,
    input  wire                   logic rst_n,
    input  wire                   logic push,
    input  wire spsp_pkg::result_t      push_data,
    output logic                        can_push,
    output logic                        out_valid,
    input  wire                   logic out_ready,
    output spsp_pkg::result_t           out_data
);

    spsp_pkg::result_t main_reg;
    spsp_pkg::result_t skid_reg;
    logic              main_valid_reg;
    logic              skid_valid_reg;
    logic              pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload: refill the result register, or park the transaction in the skid
    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (push)
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

`ifndef ASSERT_OFF
    // The skid register is only in use behind a waiting result
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds data while result register is empty");

    // A parked transaction is the next one delivered
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> main_valid_reg && (main_reg == $past(skid_reg)))
        else $error("skid transaction not delivered next");
`endif

endmodule

`default_nettype wire

### rtl/spi_slave_packet_sender.sv
// Top level of the SPI slave packet sender: stream ports and field packing.
// Depends on spsp_pkg, spsp_core and spsp_out_buf.
`default_nettype none

// Takes one transaction per clock cycle; each accepted transaction yields
// exactly one result. With the output buffer empty the result is available on
// the master side the cycle after it is accepted; otherwise it queues behind
// the waiting result. The rate is set by the single registered update step in
// spsp_core, which completes the whole packet state change in one step.
// A two-entry output buffer keeps the slave side open while one result waits
// to be taken; the slave side stalls only when both entries are full. There
// is no clearing pass after reset.
module spi_slave_packet_sender
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // sonar_byte_0, sonar_byte_1, sonar_byte_2, sonar_byte_3, lap_byte,
    // select_idle, zero padding
    input  wire logic [47:0] s_axis_tdata,
    // req_type
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // load_valid, load_byte, data_ready, buffer_full, zero padding
    output logic [15:0]      m_axis_tdata
);

    spsp_pkg::req_t    req;
    spsp_pkg::result_t result;
    spsp_pkg::result_t out_result;
    logic              accept;

    // Unpack the input transaction
    always_comb
    begin
        req.req_type    = s_axis_tuser[0];
        req.sonar[0]    = s_axis_tdata[7:0];
        req.sonar[1]    = s_axis_tdata[15:8];
        req.sonar[2]    = s_axis_tdata[23:16];
        req.sonar[3]    = s_axis_tdata[31:24];
        req.lap         = s_axis_tdata[39:32];
        req.select_idle = s_axis_tdata[40];
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    spsp_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .result (result)
    );

    spsp_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .can_push  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    // Pack the result, padded to whole bytes
    assign m_axis_tdata = {(spsp_pkg::OUT_DATA_W - spsp_pkg::RESULT_W)'(0), out_result};

endmodule

`default_nettype wire
